FILE: hw/rtl/sida_pkg.sv
// sida_pkg: widths, ascii codes and shared types of the signed integer to
// decimal ascii converter. No dependencies.
package sida_pkg;

   localparam int VALUE_WIDTH     = 32;
   localparam int DIGITS          = 10;
   localparam int BCD_WIDTH       = 4 * DIGITS;
   localparam int CHAR_WIDTH      = 8;
   localparam int SHIFT_CNT_WIDTH = $clog2(VALUE_WIDTH);
   localparam int DIGIT_CNT_WIDTH = $clog2(DIGITS + 1);

   localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO    = 8'h30;
   localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS   = 8'h2D;
   localparam logic [CHAR_WIDTH-1:0] CHAR_NEWLINE = 8'h0A;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_TRIM,
      ST_SIGN,
      ST_DIGITS,
      ST_NEWLINE
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } bcd_status_type;

endpackage

FILE: hw/rtl/sida_bcd.sv
// sida_bcd: bit-serial binary to bcd converter (shift and add three),
// one magnitude bit per cycle. Depends on sida_pkg.
module sida_bcd (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [sida_pkg::VALUE_WIDTH-1:0]  magnitude,
   output sida_pkg::bcd_status_type          status,
   output logic [sida_pkg::BCD_WIDTH-1:0]    bcd
);
   import sida_pkg::*;

   localparam logic [SHIFT_CNT_WIDTH-1:0] CNT_LAST = SHIFT_CNT_WIDTH'(VALUE_WIDTH - 1);

   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [SHIFT_CNT_WIDTH-1:0] count_ff, count_in;
   logic [VALUE_WIDTH-1:0]     bin_ff, bin_in;
   logic [BCD_WIDTH-1:0]       bcd_ff, bcd_in;
   logic [BCD_WIDTH-1:0]       corrected;

   // add three to every digit of five or more before the shift
   always_comb begin
      for (int i = 0; i < DIGITS; i++) begin
         if (bcd_ff[4*i +: 4] >= 4'd5) begin
            corrected[4*i +: 4] = bcd_ff[4*i +: 4] + 4'd3;
         end else begin
            corrected[4*i +: 4] = bcd_ff[4*i +: 4];
         end
      end
   end

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      bin_in   = bin_ff;
      bcd_in   = bcd_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         bin_in   = magnitude;
         bcd_in   = '0;
      end else if (busy_ff) begin
         bin_in   = {bin_ff[VALUE_WIDTH-2:0], 1'b0};
         bcd_in   = {corrected[BCD_WIDTH-2:0], bin_ff[VALUE_WIDTH-1]};
         count_in = count_ff + 1'b1;
         if (count_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign bcd         = bcd_ff;

endmodule

FILE: hw/rtl/signed_int_to_decimal_ascii_top.sv
// signed_int_to_decimal_ascii_top: turns a signed 32-bit integer into decimal
// ascii text, one character per word. Depends on sida_pkg and sida_bcd.
//
//   channel  dir  handshake         payload
//   req      in   req_valid/stall   req_value (32, signed)
//   rsp      out  rsp_valid/stall   rsp_character (8), rsp_last (1)
//
// a value passes through the bit-serial bcd converter, then leading zeros are
// dropped one digit at a time, keeping at least one digit, then the characters
// go out one character per cycle while the rsp side does not stall.
// reset is synchronous and clears all control state.
// req_stall is high from accept until the newline is loaded into the output
// register; rsp_stall holds that register and pauses character output.
module signed_int_to_decimal_ascii_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [sida_pkg::VALUE_WIDTH-1:0] req_value,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [sida_pkg::CHAR_WIDTH-1:0]   rsp_character,
   output logic                              rsp_last
);
   import sida_pkg::*;

   state_type                  state_ff, state_in;
   logic                       neg_ff, neg_in;
   logic [BCD_WIDTH-1:0]       digits_ff, digits_in;
   logic [DIGIT_CNT_WIDTH-1:0] num_ff, num_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [CHAR_WIDTH-1:0]      rsp_character_ff, rsp_character_in;
   logic                       rsp_last_ff, rsp_last_in;

   logic [VALUE_WIDTH-1:0] raw;
   logic [VALUE_WIDTH-1:0] magnitude;
   bcd_status_type         bcd_status;
   logic [BCD_WIDTH-1:0]   bcd;
   logic [3:0]             top_digit;
   logic                   trim_more;
   logic                   out_free;

   logic                   start;
   logic                   capture;
   logic                   shift;
   logic                   load;
   logic [CHAR_WIDTH-1:0]  char_out;
   logic                   last_out;

   // magnitude kept unsigned so the most negative value does not overflow
   assign raw       = req_value;
   assign magnitude = raw[VALUE_WIDTH-1] ? (~raw + 1'b1) : raw;

   sida_bcd u_bcd (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .magnitude (magnitude),
      .status    (bcd_status),
      .bcd       (bcd)
   );

   assign top_digit = digits_ff[BCD_WIDTH-1 -: 4];
   assign trim_more = (top_digit == 4'd0) && (num_ff > DIGIT_CNT_WIDTH'(1));
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_CONVERT;
         end
         ST_CONVERT: begin
            if (bcd_status.done) state_in = ST_TRIM;
         end
         ST_TRIM: begin
            if (!trim_more) state_in = neg_ff ? ST_SIGN : ST_DIGITS;
         end
         ST_SIGN: begin
            if (out_free) state_in = ST_DIGITS;
         end
         ST_DIGITS: begin
            if (out_free && num_ff == DIGIT_CNT_WIDTH'(1)) state_in = ST_NEWLINE;
         end
         ST_NEWLINE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      start     = 1'b0;
      capture   = 1'b0;
      shift     = 1'b0;
      load      = 1'b0;
      char_out  = CHAR_NEWLINE;
      last_out  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            start     = req_valid;
         end
         ST_CONVERT: begin
            capture = bcd_status.done;
         end
         ST_TRIM: begin
            shift = trim_more;
         end
         ST_SIGN: begin
            load     = out_free;
            char_out = CHAR_MINUS;
         end
         ST_DIGITS: begin
            load     = out_free;
            shift    = out_free;
            char_out = CHAR_ZERO + {4'd0, top_digit};
         end
         ST_NEWLINE: begin
            load     = out_free;
            last_out = 1'b1;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_comb begin
      neg_in    = neg_ff;
      digits_in = digits_ff;
      num_in    = num_ff;
      if (start) neg_in = raw[VALUE_WIDTH-1];
      if (capture) begin
         digits_in = bcd;
         num_in    = DIGIT_CNT_WIDTH'(DIGITS);
      end else if (shift) begin
         digits_in = {digits_ff[BCD_WIDTH-5:0], 4'd0};
         num_in    = num_ff - 1'b1;
      end

      rsp_valid_in     = rsp_valid_ff;
      rsp_character_in = rsp_character_ff;
      rsp_last_in      = rsp_last_ff;
      if (load) begin
         rsp_valid_in     = 1'b1;
         rsp_character_in = char_out;
         rsp_last_in      = last_out;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         neg_ff       <= 1'b0;
         num_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         neg_ff       <= neg_in;
         num_ff       <= num_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      digits_ff        <= digits_in;
      rsp_character_ff <= rsp_character_in;
      rsp_last_ff      <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = rsp_character_ff;
   assign rsp_last      = rsp_last_ff;

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_CONVERT && bcd_status.busy))
      else $error("accepted word did not start conversion");

   a_done_in_convert: assert property (@(posedge clock) disable iff (reset)
      bcd_status.done |-> (state_ff == ST_CONVERT))
      else $error("bcd result arrived outside conversion");

   a_digit_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIGITS) |-> (num_ff >= DIGIT_CNT_WIDTH'(1) &&
                                   num_ff <= DIGIT_CNT_WIDTH'(DIGITS)))
      else $error("digit count out of range while emitting");

   a_last_is_newline: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> (rsp_character_ff == CHAR_NEWLINE))
      else $error("last word is not a newline");

endmodule

FILE: verif/signed_int_to_decimal_ascii_top_test.sv
// signed_int_to_decimal_ascii_top_test: drives signed integers into the
// converter and checks every ascii word against a predicted text stream.
// Depends on sida_pkg and signed_int_to_decimal_ascii_top.
module signed_int_to_decimal_ascii_top_test;
   import sida_pkg::*;

   localparam int IDLE_LIMIT = 2000;
   localparam int RANDOM_VALUES = 150;

   typedef struct packed {
      logic [CHAR_WIDTH-1:0] character;
      logic                  last;
   } ascii_word_type;

   class ascii_scoreboard;
      ascii_word_type pending_words[$];
      int             failures = 0;

      // splits the magnitude into digits and queues the full text of one number
      function void note_value(logic signed [VALUE_WIDTH-1:0] value);
         logic [VALUE_WIDTH-1:0] magnitude;
         logic [3:0]             digits[DIGITS];
         int                     count;
         int                     i;
         ascii_word_type         word;
         // magnitude kept unsigned so the most negative value does not overflow
         magnitude = value[VALUE_WIDTH-1] ? VALUE_WIDTH'(~value + 32'd1) : value;
         count = 0;
         do begin
            digits[count] = 4'(magnitude % 10);
            magnitude = magnitude / 10;
            count++;
         end while (magnitude != 0 && count < DIGITS);
         if (value[VALUE_WIDTH-1]) begin
            word = '{CHAR_MINUS, 1'b0};
            pending_words.push_back(word);
         end
         for (i = count - 1; i >= 0; i--) begin
            word = '{CHAR_WIDTH'(CHAR_ZERO + digits[i]), 1'b0};
            pending_words.push_back(word);
         end
         word = '{CHAR_NEWLINE, 1'b1};
         pending_words.push_back(word);
      endfunction

      function void check_word(logic [CHAR_WIDTH-1:0] character, logic last);
         ascii_word_type expected;
         if (pending_words.size() == 0) begin
            $error("unexpected word: rsp_character %h rsp_last %b", character, last);
            failures++;
            return;
         end
         expected = pending_words.pop_front();
         if (character !== expected.character) begin
            $error("rsp_character: expected %h, actual %h", expected.character, character);
            failures++;
         end
         if (last !== expected.last) begin
            $error("rsp_last: expected %b, actual %b", expected.last, last);
            failures++;
         end
      endfunction
   endclass

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic signed [VALUE_WIDTH-1:0] req_value = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic [CHAR_WIDTH-1:0]         rsp_character;
   logic                          rsp_last;

   logic signed [VALUE_WIDTH-1:0] test_values[$];
   bit                            no_idle = 1'b0;
   ascii_scoreboard               text_board = new();

   signed_int_to_decimal_ascii_top uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

   always #5 clock = ~clock;

   function automatic int draw_wait();
      return no_idle ? 0 : $urandom_range(0, 15);
   endfunction

   // mixes full-range values, values of a chosen digit count, small ones and
   // values at or one below a power of ten
   function automatic logic signed [VALUE_WIDTH-1:0] random_value();
      longint low_bound;
      longint high_bound;
      longint power;
      int     length;
      logic [VALUE_WIDTH-1:0] pick;
      case ($urandom_range(0, 3))
         0: begin
            pick = $urandom();
         end
         1: begin
            length = $urandom_range(1, DIGITS);
            power = 1;
            repeat (length - 1) power = power * 10;
            low_bound = (length == 1) ? 0 : power;
            high_bound = power * 10 - 1;
            if (high_bound > 64'd2147483647) high_bound = 64'd2147483647;
            pick = $urandom_range(32'(high_bound), 32'(low_bound));
            if ($urandom_range(0, 1)) pick = ~pick + 32'd1;
         end
         2: begin
            pick = $urandom_range(0, 20);
            if ($urandom_range(0, 1)) pick = ~pick + 32'd1;
         end
         default: begin
            power = 1;
            repeat ($urandom_range(0, DIGITS - 1)) power = power * 10;
            pick = 32'(power) - 32'($urandom_range(0, 1));
            if ($urandom_range(0, 1)) pick = ~pick + 32'd1;
         end
      endcase
      return pick;
   endfunction

   task automatic drive_values();
      int gap;
      int n;
      for (n = 0; n < test_values.size(); n++) begin
         // alternate stretches with and without idling on both sides
         if (n >= 16) no_idle = (((n - 16) / 30) % 3) == 1;
         gap = draw_wait();
         if (gap > 0) begin
            @(negedge clock) req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         @(negedge clock);
         req_valid <= 1'b1;
         req_value <= test_values[n];
         do @(posedge clock); while (req_stall);
         text_board.note_value(req_value);
      end
      @(negedge clock) req_valid <= 1'b0;
      no_idle = 1'b0;
   endtask

   task automatic receive_words();
      int stall_cycles;
      forever begin
         stall_cycles = draw_wait();
         if (stall_cycles > 0) begin
            @(negedge clock) rsp_stall <= 1'b1;
            repeat (stall_cycles - 1) @(negedge clock);
         end
         @(negedge clock) rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
         text_board.check_word(rsp_character, rsp_last);
      end
   endtask

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("Test completed with failures");
      $finish;
   end

   initial begin : main
      int n;
      // sign and digit-count extremes, zero, and both bit patterns
      test_values = '{32'sd0, 32'sd1, -32'sd1, 32'sd9, 32'sd10, -32'sd10, 32'sd99,
                      32'sd100, 32'sd2147483647, 32'h80000000, -32'sd2147483647,
                      32'sd1000000000, 32'sd999999999, -32'sd999999999,
                      32'h55555555, 32'hAAAAAAAA};
      for (n = 0; n < RANDOM_VALUES; n++) test_values.push_back(random_value());

      repeat (5) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      fork
         receive_words();
      join_none
      drive_values();

      while (text_board.pending_words.size() != 0) @(posedge clock);
      // catch anything sent after the final newline
      repeat (60) @(posedge clock);

      if (text_board.failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
